@@ design/tilt_pkg.sv @@
// shared types, constants and arctangent table for the tilt angle block
package tilt_pkg;

  localparam int ACC_FRAC     = 16;  // fraction bits of the cordic angle accumulator
  localparam int ATAN_ENTRIES = 24;
  localparam int SQRT_STEPS   = 17;  // bit pairs of a 34-bit radicand
  localparam int SQ_W         = 34;
  localparam int CORD_W       = 28;
  localparam int ZACC_W       = 25;
  localparam int ANG_W        = 26;
  localparam int CNT_W        = 5;
  localparam int CFG_IDX_W    = 2;

  localparam logic signed [17:0] GRAVITY_1G = 18'sd16384;
  localparam logic [SQ_W-1:0]    SQRT_BIT0  = 34'h1_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_X     = 2'd0,
    CFG_BASE_Y     = 2'd1,
    CFG_BASE_Z     = 2'd2,
    CFG_TILT_LIMIT = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQZ,
    ST_SQRT,
    ST_CINIT,
    ST_CORD,
    ST_DONE
  } tilt_state_t;

  typedef struct packed {
    logic             load_in;
    logic             sq_x;
    logic             sq_z;
    logic             sqrt_step;
    logic             cord_init;
    logic             cord_step;
    logic             load_out;
    logic [CNT_W-1:0] step;
  } tilt_cmd_t;

  // atan(2^-i) in degrees, 16 fraction bits
  localparam logic [23:0] ATAN_DEG [ATAN_ENTRIES] = '{
    24'd2949120, 24'd1740967, 24'd919879, 24'd466945, 24'd234379, 24'd117304,
    24'd58666,   24'd29335,   24'd14668,  24'd7334,   24'd3667,   24'd1833,
    24'd917,     24'd458,     24'd229,    24'd115,    24'd57,     24'd29,
    24'd14,      24'd7,       24'd4,      24'd2,      24'd1,      24'd0
  };

endpackage

@@ design/tilt_ctrl.sv @@
// sequencer for the tilt angle block: squares, square root, cordic, output hand-off
module tilt_ctrl
  import tilt_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output tilt_cmd_t cmd
);

  localparam int NUM_ROT = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam logic [CNT_W-1:0] ROT_LAST  = CNT_W'(NUM_ROT - 1);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);

  tilt_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.step      = cnt_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_SQX;
        end
      end
      ST_SQX: begin
        cmd.sq_x  = 1'b1;
        state_nxt = ST_SQZ;
      end
      ST_SQZ: begin
        cmd.sq_z  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == SQRT_LAST) begin
          state_nxt = ST_CINIT;
        end
      end
      ST_CINIT: begin
        cmd.cord_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = ST_CORD;
      end
      ST_CORD: begin
        cmd.cord_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == ROT_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait here while the output register still holds an untaken result
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

@@ design/tilt_dp.sv @@
// datapath: offsets, shared squarer, bit-pair square root, cordic vectoring, rounding and flags
module tilt_dp
  import tilt_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tilt_cmd_t            cmd,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic signed [15:0]   in_accel_x,
  input  logic signed [15:0]   in_accel_y,
  input  logic signed [15:0]   in_accel_z,
  output logic signed [15:0]   out_tilt_angle,
  output logic                 out_over_limit,
  output logic                 out_rising
);

  localparam int RND_SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [ANG_W-1:0] RND_HALF  = ANG_W'(1) << (RND_SHIFT - 1);
  localparam logic signed [ANG_W-1:0] ANG_LIM   = ANG_W'(90) << ANGLE_FRAC_BITS;
  localparam logic signed [ANG_W-1:0] ANG_MAX16 = ANG_W'(32767);
  localparam logic signed [ANG_W-1:0] ANG_MIN16 = -ANG_W'(32768);

  // configuration
  logic signed [15:0] base_x_r, base_y_r, base_z_r;
  logic [14:0]        limit_r;
  logic signed [15:0] prev_r;

  // working registers
  logic signed [16:0]        dx_r, dy_r;
  logic signed [17:0]        dz_r;
  logic [SQ_W-1:0]           sq_r, res_r, bit_r;
  logic signed [CORD_W-1:0]  x_r, y_r;
  logic signed [ZACC_W-1:0]  z_r;
  logic signed [15:0]        angle_out_r;
  logic                      over_out_r, rise_out_r;

  logic signed [17:0]        mul_op;
  logic signed [35:0]        mul_prod;
  logic [SQ_W:0]             trial;
  logic signed [CORD_W-1:0]  xs, ys;
  logic signed [ZACC_W-1:0]  atan_step;
  logic signed [ANG_W-1:0]   rnd_sum, rnd, clamped;
  logic signed [15:0]        angle16;
  logic                      zero_vec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_x_r <= '0;
      base_y_r <= '0;
      base_z_r <= '0;
      limit_r  <= 15'd1792;
      prev_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE_X:     base_x_r <= cfg_data;
          CFG_BASE_Y:     base_y_r <= cfg_data;
          CFG_BASE_Z:     base_z_r <= cfg_data;
          CFG_TILT_LIMIT: limit_r  <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (cmd.load_out) begin
        prev_r <= angle16;
      end
    end
  end

  // one multiplier shared by both squares
  assign mul_op   = cmd.sq_x ? {dx_r[16], dx_r} : dz_r;
  assign mul_prod = mul_op * mul_op;

  assign trial     = {1'b0, res_r} + {1'b0, bit_r};
  assign xs        = x_r >>> cmd.step;
  assign ys        = y_r >>> cmd.step;
  assign atan_step = ZACC_W'(ATAN_DEG[cmd.step]);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dx_r <= 17'(in_accel_x) - 17'(base_x_r);
      dy_r <= 17'(in_accel_y) - 17'(base_y_r);
      dz_r <= 18'(in_accel_z) - GRAVITY_1G + 18'(base_z_r);
    end
    if (cmd.sq_x) begin
      sq_r  <= mul_prod[SQ_W-1:0];
      res_r <= '0;
      bit_r <= SQRT_BIT0;
    end
    if (cmd.sq_z) begin
      sq_r <= sq_r + mul_prod[SQ_W-1:0];
    end
    if (cmd.sqrt_step) begin
      if ({1'b0, sq_r} >= trial) begin
        sq_r  <= sq_r - trial[SQ_W-1:0];
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.cord_init) begin
      x_r <= CORD_W'({res_r[16:0], 8'd0});
      y_r <= CORD_W'($signed({dy_r, 8'd0}));
      z_r <= '0;
    end
    if (cmd.cord_step) begin
      if (!y_r[CORD_W-1]) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_step;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_step;
      end
    end
    if (cmd.load_out) begin
      angle_out_r <= angle16;
      over_out_r  <= angle16 > $signed({1'b0, limit_r});
      rise_out_r  <= (angle16 > 16'sd0) && (angle16 >= prev_r);
    end
  end

  // round half up, then clamp to +-90 degrees and the 16-bit range; a zero vector gives 0
  assign zero_vec = (res_r == '0) && (dy_r == '0);
  assign rnd_sum  = ANG_W'(z_r) + RND_HALF;
  assign rnd      = rnd_sum >>> RND_SHIFT;

  always_comb begin
    clamped = rnd;
    if (zero_vec) begin
      clamped = '0;
    end else if (rnd > ANG_LIM) begin
      clamped = ANG_LIM;
    end else if (rnd < -ANG_LIM) begin
      clamped = -ANG_LIM;
    end
    if (clamped > ANG_MAX16) begin
      clamped = ANG_MAX16;
    end else if (clamped < ANG_MIN16) begin
      clamped = ANG_MIN16;
    end
    angle16 = clamped[15:0];
  end

  assign out_tilt_angle = angle_out_r;
  assign out_over_limit = over_out_r;
  assign out_rising     = rise_out_r;

endmodule

@@ design/accel_tilt_angle.sv @@
// Tilt angle from one accelerometer triple: atan2(dy, sqrt(dx^2 + dz^2)) in degrees.
// Input channel: in_valid/in_ready with in_accel_x/y/z, signed 16-bit raw samples.
// Result channel: out_valid/out_ready with out_tilt_angle (signed, ANGLE_FRAC_BITS
// fraction bits), out_over_limit (angle above tilt_limit) and out_rising (angle
// positive and not below the previous result).
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0..3 write
// base_x, base_y, base_z and tilt_limit. Always ready; write only while idle.
// Sequence: after the input transfer the block squares dx and dz, takes the square
// root one bit pair per cycle, then runs one cordic micro-rotation per cycle, and
// rounds and clamps the angle into the output register. Items are processed one at
// a time: a new item is taken only once the last has reached the output register.
// A finished result sits in the output register; a new item is taken meanwhile,
// but its result waits in the last step until the receiver takes the old one.
// Reset (synchronous, rst_n low) clears offsets to 0, tilt_limit to 1792 and the
// previous angle to 0, and empties the output register.
module accel_tilt_angle
  import tilt_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   in_accel_x,
  input  logic signed [15:0]   in_accel_y,
  input  logic signed [15:0]   in_accel_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   out_tilt_angle,
  output logic                 out_over_limit,
  output logic                 out_rising,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  tilt_cmd_t cmd;

  assign cfg_ready = 1'b1;

  tilt_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  tilt_dp #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .cfg_we        (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_accel_x    (in_accel_x),
    .in_accel_y    (in_accel_y),
    .in_accel_z    (in_accel_z),
    .out_tilt_angle(out_tilt_angle),
    .out_over_limit(out_over_limit),
    .out_rising    (out_rising)
  );

endmodule
